// File: src/pzm_pkg.sv
// Shared types and constants for the pixel replication zoom.
// Used by every module of the block; no dependencies.
package pzm_pkg;

    // Field widths fixed by the interface
    localparam int SRC_COLS_W = 13;
    localparam int COORD_W    = 12;
    localparam int REGION_W   = 11;
    localparam int MAG_W      = 4;
    localparam int PIX_W      = 8;
    localparam int DEST_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Defaults for the top level parameters
    localparam int DEF_MAX_REGION_COLS = 1024;
    localparam int DEF_MAX_REGION_ROWS = 1024;
    localparam int DEF_MAX_MAG         = 8;
    localparam int DEF_QUEUE_DEPTH     = 4;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_COLS   = 3'd0,
        CFG_WINDOW_X      = 3'd1,
        CFG_WINDOW_Y      = 3'd2,
        CFG_REGION_COLS   = 3'd3,
        CFG_REGION_ROWS   = 3'd4,
        CFG_MAG           = 3'd5,
        CFG_IMAGE_PRESENT = 3'd6
    } cfg_index_t;

    // Configuration register set
    typedef struct packed {
        logic [SRC_COLS_W-1:0] source_cols;
        logic [COORD_W-1:0]    window_x;
        logic [COORD_W-1:0]    window_y;
        logic [REGION_W-1:0]   region_cols;
        logic [REGION_W-1:0]   region_rows;
        logic [MAG_W-1:0]      mag;
        logic                  image_present;
    } pzm_cfg_t;

    // One classified window pixel, ready for block expansion
    typedef struct packed {
        logic [DEST_W-1:0] base_x;
        logic [DEST_W-1:0] base_y;
        logic [MAG_W-1:0]  mag;
        logic [PIX_W-1:0]  image;
        logic              image_write;
        logic [PIX_W-1:0]  mask;
        logic [PIX_W-1:0]  blend;
    } pzm_desc_t;

endpackage

// File: src/pzm_front.sv
// Front end: accepts source pixels, tracks column/row, crops to the window.
// Depends on pzm_pkg; feeds block descriptors into pzm_queue.
module pzm_front #(
    parameter int MAX_REGION_COLS = pzm_pkg::DEF_MAX_REGION_COLS,
    parameter int MAX_REGION_ROWS = pzm_pkg::DEF_MAX_REGION_ROWS,
    parameter int MAX_MAG         = pzm_pkg::DEF_MAX_MAG
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pzm_pkg::pzm_cfg_t            cfg,
    input  logic                         accept,
    input  logic                         start_of_frame,
    input  logic [pzm_pkg::PIX_W-1:0]    image_pixel,
    input  logic [pzm_pkg::PIX_W-1:0]    mask_pixel,
    input  logic [pzm_pkg::PIX_W-1:0]    blend_pixel,
    output logic                         desc_push,
    output pzm_pkg::pzm_desc_t           desc
);
    import pzm_pkg::*;

    logic [COORD_W-1:0]    col_reg, col_next;
    logic [COORD_W-1:0]    row_reg, row_next;
    logic [COORD_W-1:0]    col_cur, row_cur;
    logic [MAG_W-1:0]      m_sat;
    logic [SRC_COLS_W-1:0] rc_sat, rr_sat;
    logic [SRC_COLS_W-1:0] x_end, y_end;
    logic                  in_x, in_y;
    logic [COORD_W-1:0]    rx, ry;
    logic [COORD_W+MAG_W-1:0] prod_x, prod_y;
    logic                  line_end;

    // Position of this pixel; start of frame forces the origin
    assign col_cur = start_of_frame ? '0 : col_reg;
    assign row_cur = start_of_frame ? '0 : row_reg;

    // Saturate magnification and window size
    assign m_sat  = (cfg.mag > MAG_W'(MAX_MAG)) ? MAG_W'(MAX_MAG) : cfg.mag;
    assign rc_sat = ({2'b00, cfg.region_cols} > SRC_COLS_W'(MAX_REGION_COLS)) ?
                    SRC_COLS_W'(MAX_REGION_COLS) : {2'b00, cfg.region_cols};
    assign rr_sat = ({2'b00, cfg.region_rows} > SRC_COLS_W'(MAX_REGION_ROWS)) ?
                    SRC_COLS_W'(MAX_REGION_ROWS) : {2'b00, cfg.region_rows};

    // Window test
    assign x_end = {1'b0, cfg.window_x} + rc_sat;
    assign y_end = {1'b0, cfg.window_y} + rr_sat;
    assign in_x  = (col_cur >= cfg.window_x) && ({1'b0, col_cur} < x_end);
    assign in_y  = (row_cur >= cfg.window_y) && ({1'b0, row_cur} < y_end);

    // Block origin in the destination image
    assign rx     = col_cur - cfg.window_x;
    assign ry     = row_cur - cfg.window_y;
    assign prod_x = {{MAG_W{1'b0}}, rx} * {{COORD_W{1'b0}}, m_sat};
    assign prod_y = {{MAG_W{1'b0}}, ry} * {{COORD_W{1'b0}}, m_sat};

    assign desc_push        = accept && (m_sat != '0) && in_x && in_y;
    assign desc.base_x      = prod_x[DEST_W-1:0];
    assign desc.base_y      = prod_y[DEST_W-1:0];
    assign desc.mag         = m_sat;
    assign desc.image       = cfg.image_present ? image_pixel : '0;
    assign desc.image_write = cfg.image_present;
    assign desc.mask        = mask_pixel;
    assign desc.blend       = blend_pixel;

    // Advance the raster position, wrapping at the end of a line
    assign line_end = (({1'b0, col_cur} + SRC_COLS_W'(1)) >= cfg.source_cols) ||
                      (col_cur == '1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (line_end)
            begin
                col_next = '0;
                row_next = row_cur + COORD_W'(1);
            end
            else
            begin
                col_next = col_cur + COORD_W'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: src/pzm_queue.sv
// Short descriptor queue between front end and block expander.
// Depends on pzm_pkg for the descriptor type.
module pzm_queue #(
    parameter int DEPTH = pzm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pzm_pkg::pzm_desc_t push_data,
    input  logic               pop,
    output pzm_pkg::pzm_desc_t head,
    output logic               full,
    output logic               empty
);
    import pzm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pzm_desc_t         mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed descriptors
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue push did not grow occupancy");
    a_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with occupancy");
`endif

endmodule

// File: src/pzm_back.sv
// Back end: expands each descriptor into a mag-by-mag block of results.
// Depends on pzm_pkg; reads the head of pzm_queue, drives the result ports.
module pzm_back #(
    parameter int MAX_MAG = pzm_pkg::DEF_MAX_MAG
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pzm_pkg::pzm_desc_t          head,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [pzm_pkg::DEST_W-1:0]  dest_x,
    output logic [pzm_pkg::DEST_W-1:0]  dest_y,
    output logic [pzm_pkg::PIX_W-1:0]   image_out,
    output logic                        image_write,
    output logic [pzm_pkg::PIX_W-1:0]   mask_out,
    output logic [pzm_pkg::PIX_W-1:0]   blend_out,
    output logic                        block_last
);
    import pzm_pkg::*;

    localparam int DX_W = (MAX_MAG > 1) ? $clog2(MAX_MAG) : 1;

    logic [DX_W-1:0]   dx_reg, dx_next;
    logic [DX_W-1:0]   dy_reg, dy_next;
    logic              out_valid_reg, out_valid_next;
    logic [DEST_W-1:0] dest_x_reg, dest_y_reg;
    logic [PIX_W-1:0]  image_reg, mask_reg, blend_reg;
    logic              image_write_reg, block_last_reg;
    logic              load, row_end, col_end, blk_last;
    logic [MAG_W-1:0]  m_last;

    // Load a new result when the output register is free or being taken
    assign load     = !q_empty && (!out_valid_reg || pop);
    assign m_last   = head.mag - MAG_W'(1);
    assign row_end  = (MAG_W'(dx_reg) == m_last);
    assign col_end  = (MAG_W'(dy_reg) == m_last);
    assign blk_last = row_end && col_end;
    assign q_pop    = load && blk_last;

    // Step dx inner, dy outer
    always_comb
    begin
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (row_end)
            begin
                dx_next = '0;
                dy_next = col_end ? '0 : dy_reg + DX_W'(1);
            end
            else
            begin
                dx_next = dx_reg + DX_W'(1);
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg        <= '0;
            dy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dest_x_reg      <= head.base_x + DEST_W'(dx_reg);
            dest_y_reg      <= head.base_y + DEST_W'(dy_reg);
            image_reg       <= head.image;
            image_write_reg <= head.image_write;
            mask_reg        <= head.mask;
            blend_reg       <= head.blend;
            block_last_reg  <= blk_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign dest_x      = dest_x_reg;
    assign dest_y      = dest_y_reg;
    assign image_out   = image_reg;
    assign image_write = image_write_reg;
    assign mask_out    = mask_reg;
    assign blend_out   = blend_reg;
    assign block_last  = block_last_reg;

`ifndef SYNTHESIS
    a_dx_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (MAG_W'(dx_reg) < head.mag))
        else $error("column step outside block");
    a_dy_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (MAG_W'(dy_reg) < head.mag))
        else $error("row step outside block");
    a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (load && blk_last) |=> (dx_reg == '0 && dy_reg == '0))
        else $error("block counters not cleared after last result");
`endif

endmodule

// File: src/pixel_replicate_zoom.sv
// Top level of the pixel replication zoom: configuration registers and glue.
// Depends on pzm_pkg, pzm_front, pzm_queue and pzm_back.
//
// Source pixels enter on push/full in raster order, one per cycle while the
// descriptor queue has room. Pixels outside the configured window (or any
// pixel when mag is zero) are accepted and produce nothing. Each
// window pixel produces a block of mag*mag results, dy outer and dx inner,
// and the result side emits one result per cycle while pop is held and a
// descriptor is waiting, so sustained throughput is set by the block
// expander (4 results per window pixel at the reset mag of 2). On an idle
// block a pixel's descriptor is first written into the queue and then the
// first result of its block is loaded into the output register.
// Configuration writes take effect on the next cycle and must happen while the block is idle.
module pixel_replicate_zoom #(
    parameter int MAX_REGION_COLS = pzm_pkg::DEF_MAX_REGION_COLS,
    parameter int MAX_REGION_ROWS = pzm_pkg::DEF_MAX_REGION_ROWS,
    parameter int MAX_MAG         = pzm_pkg::DEF_MAX_MAG,
    parameter int QUEUE_DEPTH     = pzm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [pzm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pzm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            start_of_frame,
    input  logic [pzm_pkg::PIX_W-1:0]       image_pixel,
    input  logic [pzm_pkg::PIX_W-1:0]       mask_pixel,
    input  logic [pzm_pkg::PIX_W-1:0]       blend_pixel,
    output logic                            empty,
    input  logic                            pop,
    output logic [pzm_pkg::DEST_W-1:0]      dest_x,
    output logic [pzm_pkg::DEST_W-1:0]      dest_y,
    output logic [pzm_pkg::PIX_W-1:0]       image_out,
    output logic                            image_write,
    output logic [pzm_pkg::PIX_W-1:0]       mask_out,
    output logic [pzm_pkg::PIX_W-1:0]       blend_out,
    output logic                            block_last
);
    import pzm_pkg::*;

    pzm_cfg_t  cfg_reg;
    pzm_desc_t front_desc, q_head;
    logic      desc_push, q_full, q_empty, q_pop, accept;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_cols   <= SRC_COLS_W'(512);
            cfg_reg.window_x      <= '0;
            cfg_reg.window_y      <= '0;
            cfg_reg.region_cols   <= REGION_W'(256);
            cfg_reg.region_rows   <= REGION_W'(256);
            cfg_reg.mag           <= MAG_W'(2);
            cfg_reg.image_present <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SOURCE_COLS:   cfg_reg.source_cols   <= cfg_data[SRC_COLS_W-1:0];
                CFG_WINDOW_X:      cfg_reg.window_x      <= cfg_data[COORD_W-1:0];
                CFG_WINDOW_Y:      cfg_reg.window_y      <= cfg_data[COORD_W-1:0];
                CFG_REGION_COLS:   cfg_reg.region_cols   <= cfg_data[REGION_W-1:0];
                CFG_REGION_ROWS:   cfg_reg.region_rows   <= cfg_data[REGION_W-1:0];
                CFG_MAG:           cfg_reg.mag           <= cfg_data[MAG_W-1:0];
                CFG_IMAGE_PRESENT: cfg_reg.image_present <= cfg_data[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Take an item whenever the queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    pzm_front #(
        .MAX_REGION_COLS (MAX_REGION_COLS),
        .MAX_REGION_ROWS (MAX_REGION_ROWS),
        .MAX_MAG         (MAX_MAG)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .accept         (accept),
        .start_of_frame (start_of_frame),
        .image_pixel    (image_pixel),
        .mask_pixel     (mask_pixel),
        .blend_pixel    (blend_pixel),
        .desc_push      (desc_push),
        .desc           (front_desc)
    );

    pzm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (desc_push),
        .push_data (front_desc),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    pzm_back #(
        .MAX_MAG (MAX_MAG)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .dest_x      (dest_x),
        .dest_y      (dest_y),
        .image_out   (image_out),
        .image_write (image_write),
        .mask_out    (mask_out),
        .blend_out   (blend_out),
        .block_last  (block_last)
    );

endmodule
